FILE: src/sah_pkg.sv
// Shared types, constants and helper functions for the S-box avalanche histogram unit.
// Depends on nothing; every other file imports it.
package sah_pkg;

  localparam int ROUNDS      = 1;
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_BINS    = 129;
  localparam int BIN_W       = 8;
  localparam int BIN_COUNT_W = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [63:0] BASE_RESET = 64'h1234_5678_9ABC_DEF0;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_HIGH = 1'b0,
    REG_BASE_LOW  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [63:0]      block_high;
    logic [63:0]      block_low;
    logic [BIN_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [63:0]            subst_high;
    logic [63:0]            subst_low;
    logic [BIN_W-1:0]       distance;
    logic [BIN_COUNT_W-1:0] bin_count;
  } out_t;

  // Write side of the histogram store.
  typedef struct packed {
    logic                   en;
    logic                   clr;
    logic [BIN_W-1:0]       addr;
    logic [COUNT_WIDTH-1:0] data;
  } hist_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // One SubBytes pass over all sixteen bytes.
  function automatic logic [127:0] sub_block(input logic [127:0] b);
    logic [127:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      r[8*k +: 8] = SBOX[b[8*k +: 8]];
    end
    return r;
  endfunction

  function automatic logic [127:0] sub_rounds(input logic [127:0] b);
    logic [127:0] r;
    r = b;
    for (int i = 0; i < ROUNDS; i++) begin
      r = sub_block(r);
    end
    return r;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Byte counts summed as a tree by synthesis.
  function automatic logic [BIN_W-1:0] pop128(input logic [127:0] v);
    logic [BIN_W-1:0] n;
    n = '0;
    for (int k = 0; k < 16; k++) begin
      n = n + BIN_W'(pop8(v[8*k +: 8]));
    end
    return n;
  endfunction

endpackage

FILE: src/sah_calc.sv
// S-box rounds on the test and base blocks, and their bit distance.
// Depends on sah_pkg.
module sah_calc (
  input  logic [127:0]             block,
  input  logic [127:0]             base,
  output logic [127:0]             subst,
  output logic [sah_pkg::BIN_W-1:0] distance
);
  import sah_pkg::*;

  logic [127:0] base_subst;

  always_comb begin
    subst      = sub_rounds(block);
    base_subst = sub_rounds(base);
    distance   = pop128(subst ^ base_subst);
  end

endmodule

FILE: src/sah_hist.sv
// Histogram store: 129 counters in a memory with registered read, plus per-bin valid
// bits that reset and the clear command wipe at once. Depends on sah_pkg.
module sah_hist (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [sah_pkg::BIN_W-1:0]       rd_addr,
  output logic [sah_pkg::COUNT_WIDTH-1:0] rd_data,
  input  logic [sah_pkg::BIN_W-1:0]       vld_addr,
  output logic                            vld,
  input  sah_pkg::hist_wr_t               wr
);
  import sah_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr) begin
      bin_vld <= '0;
    end else if (wr.en) begin
      bin_vld[wr.addr] <= 1'b1;
    end
  end

  assign vld = bin_vld[vld_addr];

endmodule

FILE: src/sbox_avalanche_histogram_unit.sv
// Top level of the S-box avalanche histogram unit: input stage, histogram update
// stage and result register. Depends on sah_pkg, sah_calc and sah_hist.
//
//  channel | signals                          | beat
//  --------+----------------------------------+----------------------------
//  in      | in_valid, in_ready, in_data      | command, test block, bin
//  out     | out_valid, out_ready, out_data   | substituted block, distance, count
//  cfg     | cfg_write, cfg_index, cfg_data   | base block halves
//
// One beat is taken every cycle unless a held result stalls the stages; each beat
// passes the input, update and result registers. Counters are read and written
// on separate ports, and a one-entry bypass keeps repeated bins at full rate.
// Reset clears all counters at once through per-bin valid bits; no sweep is needed.
// Each stage moves forward when the one after it is empty or moving, so a held
// result does not stop the earlier stages from filling.
module sbox_avalanche_histogram_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sah_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sah_pkg::out_t                 out_data,
  input  logic                          cfg_write,
  input  logic [sah_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import sah_pkg::*;

  logic [63:0] base_high;
  logic [63:0] base_low;

  logic s1_valid;
  in_t  s1_item;

  logic [127:0]     c_subst;
  logic [BIN_W-1:0] c_distance;
  logic [BIN_W-1:0] s1_addr;
  logic             s1_in_range;

  logic             s2_valid;
  cmd_t             s2_cmd;
  logic [127:0]     s2_subst;
  logic [BIN_W-1:0] s2_addr;
  logic             s2_in_range;

  logic                   fwd_en;
  logic [BIN_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic                   en_out;
  logic                   en2;
  logic                   en1;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   bin_vld;
  logic [COUNT_WIDTH-1:0] cur;
  hist_wr_t               wr;
  out_t                   result;

  assign en_out   = !out_valid || out_ready;
  assign en2      = !s2_valid || en_out;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_high <= BASE_RESET;
      base_low  <= BASE_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_HIGH: base_high <= cfg_data;
        REG_BASE_LOW:  base_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_item <= in_data;
    end
  end

  sah_calc u_calc (
    .block    ({s1_item.block_high, s1_item.block_low}),
    .base     ({base_high, base_low}),
    .subst    (c_subst),
    .distance (c_distance)
  );

  // The counter address is the distance on submit, else the requested bin (0 if out of range).
  always_comb begin
    if (cmd_t'(s1_item.command) == CMD_SUBMIT) begin
      s1_addr     = c_distance;
      s1_in_range = 1'b1;
    end else begin
      s1_in_range = s1_item.bin_index < BIN_W'(NUM_BINS);
      s1_addr     = s1_in_range ? s1_item.bin_index : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cmd      <= cmd_t'(s1_item.command);
      s2_subst    <= c_subst;
      s2_addr     <= s1_addr;
      s2_in_range <= s1_in_range;
    end
  end

  sah_hist u_hist (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (en2 && s1_valid),
    .rd_addr  (s1_addr),
    .rd_data  (rd_data),
    .vld_addr (s2_addr),
    .vld      (bin_vld),
    .wr       (wr)
  );

  // The memory read for this item happened at the edge where the previous item
  // wrote back, so that write is taken from the bypass register instead.
  always_comb begin
    if (fwd_en && fwd_addr == s2_addr) begin
      cur = fwd_data;
    end else if (bin_vld) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    wr      = '0;
    wr.addr = s2_addr;
    wr.data = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);
    result  = '0;
    case (s2_cmd)
      CMD_SUBMIT: begin
        wr.en             = s2_valid && en_out;
        result.subst_high = s2_subst[127:64];
        result.subst_low  = s2_subst[63:0];
        result.distance   = s2_addr;
      end
      CMD_READ: begin
        if (s2_in_range) begin
          result.bin_count = BIN_COUNT_W'(cur);
        end
      end
      CMD_CLEAR: begin
        wr.clr = s2_valid && en_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else if (en2) begin
      fwd_en <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      fwd_addr <= wr.addr;
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_valid) begin
      out_data <= result;
    end
  end

endmodule

FILE: src/sah_checker.sv
// Port-level checks for the S-box avalanche histogram unit, bound to the top level.
// Depends on sah_pkg.
module sah_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sah_pkg::out_t out_data
);
  import sah_pkg::*;

  // A held result keeps its beat until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.distance <= BIN_W'(NUM_BINS - 1))
    else $error("distance beyond 128");

  // A read result carries nothing but the count.
  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bin_count != '0 |->
      out_data.subst_high == '0 && out_data.subst_low == '0 && out_data.distance == '0)
    else $error("read result carries submit fields");

  // With the result register empty every stage can move, so input is always open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

bind sbox_avalanche_histogram_unit sah_checker u_sah_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
